FILE: rtl/nte_pkg.sv
package nte_pkg;

  localparam logic [1:0] ACT_HEARD  = 2'd0;
  localparam logic [1:0] ACT_ADV    = 2'd1;
  localparam logic [1:0] ACT_ELEM   = 2'd2;
  localparam logic [1:0] ACT_EXPIRE = 2'd3;

  localparam logic [1:0] LINK_NONE = 2'd0;
  localparam logic [1:0] LINK_ASYM = 2'd1;
  localparam logic [1:0] LINK_SYM  = 2'd2;

  localparam logic [1:0] ADV_KIND_SEL = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_SRC = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic [1:0] CFG_SELF   = 2'd0;
  localparam logic [1:0] CFG_HOLD   = 2'd1;
  localparam logic [1:0] CFG_MARGIN = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_RD,
    OP_EVAL,
    OP_COMMIT,
    OP_NOADV,
    OP_RD_TGT,
    OP_ELEM,
    OP_NEXT,
    OP_DROP,
    OP_RD_LAST,
    OP_MOVE,
    OP_EXP_FIN
  } op_t;

  typedef struct packed {
    logic [1:0] act;
    logic       adv_ok;
    logic       idx_end;
    logic       idx_last;
    logic       stale_rd;
  } stat_t;

endpackage

FILE: rtl/neighbour_table_with_eviction_core.sv
// Operation: a heard or advert item scans every held entry (read, then evaluate) and then
// commits; an advert element reads the open advert's target entry and may update it, or is
// ignored with no open advert; an expire sweep reads each entry and keeps or drops it, moving
// the last entry into a dropped entry's place unless it was the last. One item at a time: the
// next is accepted in the cycle done is shown. done cannot be stalled.
// Synchronous reset empties the table, closes any advert and restores register defaults.
module neighbour_table_with_eviction_core #(
  parameter int MAX_ENTRIES = 16,
  parameter int ADDR_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [1:0]                              action,
  input  logic [ADDR_BITS-1:0]                    from_addr,
  input  logic [7:0]                              link_quality,
  input  logic [31:0]                             slot_now,
  input  logic [ADDR_BITS-1:0]                    adv_addr,
  input  logic [1:0]                              adv_kind,
  output logic                                    done,
  output logic [1:0]                              status,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]        dropped,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]        entry_count,
  output logic [1:0]                              link_state,
  output logic                                    relay_for,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [1:0]                              cfg_index,
  input  logic [((ADDR_BITS > 16) ? ADDR_BITS : 16)-1:0] cfg_data
);

  nte_pkg::op_t   op;
  nte_pkg::stat_t st;

  nte_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .op    (op),
    .st    (st)
  );

  nte_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .st           (st),
    .action       (action),
    .from_addr    (from_addr),
    .link_quality (link_quality),
    .slot_now     (slot_now),
    .adv_addr     (adv_addr),
    .adv_kind     (adv_kind),
    .done         (done),
    .status       (status),
    .dropped      (dropped),
    .entry_count  (entry_count),
    .link_state   (link_state),
    .relay_for    (relay_for),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule

FILE: rtl/nte_ctrl.sv
module nte_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output nte_pkg::op_t  op,
  input  nte_pkg::stat_t st
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_LK_RD,
    S_LK_EVAL,
    S_ELEM,
    S_EXP_RD,
    S_EXP_CHK,
    S_EXP_MOVE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    op = nte_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          op = nte_pkg::OP_LATCH;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (st.act)
          nte_pkg::ACT_ELEM: begin
            if (st.adv_ok) begin
              op = nte_pkg::OP_RD_TGT;
              state_next = S_ELEM;
            end else begin
              op = nte_pkg::OP_NOADV;
              state_next = S_IDLE;
            end
          end
          nte_pkg::ACT_EXPIRE: state_next = S_EXP_RD;
          default: state_next = S_LK_RD;
        endcase
      end
      S_LK_RD: begin
        if (st.idx_end) begin
          op = nte_pkg::OP_COMMIT;
          state_next = S_IDLE;
        end else begin
          op = nte_pkg::OP_RD;
          state_next = S_LK_EVAL;
        end
      end
      S_LK_EVAL: begin
        op = nte_pkg::OP_EVAL;
        state_next = S_LK_RD;
      end
      S_ELEM: begin
        op = nte_pkg::OP_ELEM;
        state_next = S_IDLE;
      end
      S_EXP_RD: begin
        if (st.idx_end) begin
          op = nte_pkg::OP_EXP_FIN;
          state_next = S_IDLE;
        end else begin
          op = nte_pkg::OP_RD;
          state_next = S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        if (!st.stale_rd) begin
          op = nte_pkg::OP_NEXT;
          state_next = S_EXP_RD;
        end else if (st.idx_last) begin
          op = nte_pkg::OP_DROP;
          state_next = S_EXP_RD;
        end else begin
          op = nte_pkg::OP_RD_LAST;
          state_next = S_EXP_MOVE;
        end
      end
      S_EXP_MOVE: begin
        op = nte_pkg::OP_MOVE;
        state_next = S_EXP_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
    end else begin
      state <= state_next;
      busy <= (state_next != S_IDLE);
    end
  end

endmodule

FILE: rtl/nte_dp.sv
module nte_dp #(
  parameter int MAX_ENTRIES = 16,
  parameter int ADDR_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  nte_pkg::op_t                            op,
  output nte_pkg::stat_t                          st,
  input  logic [1:0]                              action,
  input  logic [ADDR_BITS-1:0]                    from_addr,
  input  logic [7:0]                              link_quality,
  input  logic [31:0]                             slot_now,
  input  logic [ADDR_BITS-1:0]                    adv_addr,
  input  logic [1:0]                              adv_kind,
  output logic                                    done,
  output logic [1:0]                              status,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]        dropped,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]        entry_count,
  output logic [1:0]                              link_state,
  output logic                                    relay_for,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [1:0]                              cfg_index,
  input  logic [((ADDR_BITS > 16) ? ADDR_BITS : 16)-1:0] cfg_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [1:0]           link;
    logic [7:0]           str;
    logic                 sel;
    logic [31:0]          last;
  } entry_t;

  entry_t mem [MAX_ENTRIES];
  entry_t rd_data;

  logic [ADDR_BITS-1:0] self_addr;
  logic [15:0]          hold_slots;
  logic [7:0]           evict_margin;

  logic [1:0]           it_act;
  logic [ADDR_BITS-1:0] it_from;
  logic [7:0]           it_q;
  logic [31:0]          it_slot;
  logic [ADDR_BITS-1:0] it_adv;
  logic [1:0]           it_code;

  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] used_m1;
  logic [AW-1:0]    adv_target;
  logic             adv_active;

  logic          found;
  logic [AW-1:0] found_idx;
  entry_t        found_ent;
  logic          t1_v, t2_v, t3_v;
  logic [AW-1:0] t1_idx, t2_idx, t3_idx;
  logic [31:0]   t1_slot;
  logic [7:0]    t2_str, t3_str;

  logic       rd_en;
  logic [AW-1:0] rd_addr;
  logic       we;
  logic [AW-1:0] wa;
  entry_t     wd;

  logic       rd_stale;
  logic       thr_ok;
  logic [7:0] thr;
  logic       hit_now, t1_now, t2_now, t3_now;

  entry_t     base;
  entry_t     upd;
  entry_t     elem_upd;
  logic       cm_ok;
  logic       cm_grow;
  logic [AW-1:0] cm_idx;
  logic       bad;

  assign cfg_ready = 1'b1;
  assign entry_count = used;
  assign used_m1 = used - 1'b1;

  assign bad = (it_from == self_addr) || it_from[ADDR_BITS-1];
  assign rd_stale = (it_slot > rd_data.last) && ((it_slot - rd_data.last) > {16'd0, hold_slots});
  assign thr_ok = it_q > evict_margin;
  assign thr = it_q - evict_margin;

  assign hit_now = !found && (rd_data.addr == it_from);
  assign t1_now = rd_stale && (!t1_v || (rd_data.last < t1_slot));
  assign t2_now = thr_ok && (rd_data.link != nte_pkg::LINK_SYM) && (rd_data.str < thr) &&
                  (!t2_v || (rd_data.str < t2_str));
  assign t3_now = thr_ok && !rd_data.sel && (rd_data.str < thr) &&
                  (!t3_v || (rd_data.str < t3_str));

  always_comb begin
    st.act = it_act;
    st.adv_ok = adv_active && (CNT_W'(adv_target) < used);
    st.idx_end = (idx >= used);
    st.idx_last = (idx == used_m1);
    st.stale_rd = rd_stale;
  end

  always_comb begin
    base = '0;
    base.addr = it_from;
    cm_ok = 1'b1;
    cm_grow = 1'b0;
    cm_idx = '0;
    if (found) begin
      base = found_ent;
      cm_idx = found_idx;
    end else if (used < CNT_W'(MAX_ENTRIES)) begin
      cm_idx = used[AW-1:0];
      cm_grow = 1'b1;
    end else if (t1_v) begin
      cm_idx = t1_idx;
    end else if (t2_v) begin
      cm_idx = t2_idx;
    end else if (t3_v) begin
      cm_idx = t3_idx;
    end else begin
      cm_ok = 1'b0;
    end
    upd = base;
    upd.last = it_slot;
    if (it_act == nte_pkg::ACT_HEARD) begin
      upd.str = it_q;
      if (base.link == nte_pkg::LINK_NONE) begin
        upd.link = nte_pkg::LINK_ASYM;
      end
    end else begin
      upd.sel = 1'b0;
    end
  end

  always_comb begin
    elem_upd = rd_data;
    elem_upd.link = nte_pkg::LINK_SYM;
    if (it_code == nte_pkg::ADV_KIND_SEL) begin
      elem_upd.sel = 1'b1;
    end
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = idx[AW-1:0];
    we = 1'b0;
    wa = cm_idx;
    wd = upd;
    case (op)
      nte_pkg::OP_RD: rd_en = 1'b1;
      nte_pkg::OP_RD_TGT: begin
        rd_en = 1'b1;
        rd_addr = adv_target;
      end
      nte_pkg::OP_RD_LAST: begin
        rd_en = 1'b1;
        rd_addr = used_m1[AW-1:0];
      end
      nte_pkg::OP_COMMIT: we = !bad && cm_ok;
      nte_pkg::OP_ELEM: begin
        we = (it_adv == self_addr);
        wa = adv_target;
        wd = elem_upd;
      end
      nte_pkg::OP_MOVE: begin
        we = 1'b1;
        wa = idx[AW-1:0];
        wd = rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      self_addr <= '0;
      hold_slots <= 16'd64;
      evict_margin <= 8'd8;
    end else if (cfg_valid) begin
      case (cfg_index)
        nte_pkg::CFG_SELF: self_addr <= cfg_data[ADDR_BITS-1:0];
        nte_pkg::CFG_HOLD: hold_slots <= cfg_data[15:0];
        nte_pkg::CFG_MARGIN: evict_margin <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      adv_target <= '0;
      adv_active <= 1'b0;
      done <= 1'b0;
      idx <= '0;
      found <= 1'b0;
      t1_v <= 1'b0;
      t2_v <= 1'b0;
      t3_v <= 1'b0;
    end else begin
      done <= 1'b0;
      case (op)
        nte_pkg::OP_LATCH: begin
          it_act <= action;
          it_from <= from_addr;
          it_q <= (action == nte_pkg::ACT_HEARD) ? link_quality : 8'd0;
          it_slot <= slot_now;
          it_adv <= adv_addr;
          it_code <= adv_kind;
          idx <= '0;
          dropped <= '0;
          found <= 1'b0;
          t1_v <= 1'b0;
          t2_v <= 1'b0;
          t3_v <= 1'b0;
          if (action != nte_pkg::ACT_ELEM) begin
            adv_active <= 1'b0;
          end
        end
        nte_pkg::OP_EVAL: begin
          idx <= idx + 1'b1;
          if (hit_now) begin
            found <= 1'b1;
            found_idx <= idx[AW-1:0];
            found_ent <= rd_data;
          end
          if (t1_now) begin
            t1_v <= 1'b1;
            t1_idx <= idx[AW-1:0];
            t1_slot <= rd_data.last;
          end
          if (t2_now) begin
            t2_v <= 1'b1;
            t2_idx <= idx[AW-1:0];
            t2_str <= rd_data.str;
          end
          if (t3_now) begin
            t3_v <= 1'b1;
            t3_idx <= idx[AW-1:0];
            t3_str <= rd_data.str;
          end
        end
        nte_pkg::OP_COMMIT: begin
          done <= 1'b1;
          if (bad) begin
            status <= nte_pkg::ST_BAD_SRC;
            link_state <= found ? found_ent.link : nte_pkg::LINK_NONE;
            relay_for <= found && (found_ent.link == nte_pkg::LINK_SYM) && found_ent.sel;
          end else if (!cm_ok) begin
            status <= nte_pkg::ST_FULL;
            link_state <= nte_pkg::LINK_NONE;
            relay_for <= 1'b0;
          end else begin
            status <= nte_pkg::ST_OK;
            link_state <= upd.link;
            relay_for <= (upd.link == nte_pkg::LINK_SYM) && upd.sel;
            if (cm_grow) begin
              used <= used + 1'b1;
            end
            if (it_act == nte_pkg::ACT_ADV) begin
              adv_target <= cm_idx;
              adv_active <= 1'b1;
            end
          end
        end
        nte_pkg::OP_NOADV: begin
          done <= 1'b1;
          status <= nte_pkg::ST_IGNORED;
          link_state <= nte_pkg::LINK_NONE;
          relay_for <= 1'b0;
        end
        nte_pkg::OP_ELEM: begin
          done <= 1'b1;
          if (it_adv == self_addr) begin
            status <= nte_pkg::ST_OK;
            link_state <= elem_upd.link;
            relay_for <= elem_upd.sel;
          end else begin
            status <= nte_pkg::ST_IGNORED;
            link_state <= rd_data.link;
            relay_for <= (rd_data.link == nte_pkg::LINK_SYM) && rd_data.sel;
          end
        end
        nte_pkg::OP_NEXT: idx <= idx + 1'b1;
        nte_pkg::OP_DROP, nte_pkg::OP_MOVE: begin
          used <= used_m1;
          dropped <= dropped + 1'b1;
        end
        nte_pkg::OP_EXP_FIN: begin
          done <= 1'b1;
          status <= nte_pkg::ST_OK;
          link_state <= nte_pkg::LINK_NONE;
          relay_for <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) used <= CNT_W'(MAX_ENTRIES))
    else $error("entry count exceeds table size");

  assert property (@(posedge clk) disable iff (rst)
    adv_active |-> (CNT_W'(adv_target) < used))
    else $error("open advert points outside the table");

  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  assert property (@(posedge clk) disable iff (rst)
    (done && (dropped != '0)) |-> (it_act == nte_pkg::ACT_EXPIRE))
    else $error("entries dropped by an item that is not an expire sweep");

endmodule
